/* rtl/sfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

    localparam int DEF_WIDTH  = 160;
    localparam int DEF_HEIGHT = 160;

    localparam logic [15:0] RGB_RED   = 16'hF800;
    localparam logic [15:0] RGB_GREEN = 16'h07E0;
    localparam logic [15:0] RGB_BLUE  = 16'h001F;

    typedef enum logic [1:0] {
        KIND_DRAW  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_SCAN  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
    } t_item;

    typedef struct packed {
        logic        pixel;
        logic [15:0] bus_word;
        logic        last_word;
    } t_result;

    function automatic logic [15:0] group_to_rgb565(input logic [2:0] g);
        logic [15:0] w;
        w = '0;
        if (g[0]) w = w | RGB_RED;
        if (g[1]) w = w | RGB_GREEN;
        if (g[2]) w = w | RGB_BLUE;
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfs_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfs_store #(
    parameter int DEPTH = 3360,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/subpixel_framebuffer_scanout_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// One-bit-per-subpixel frame store with RGB565 scan-out. Every item gives exactly one
// result, strobed by o_valid for one cycle; the receiver cannot stall it. All store
// accesses go through one single-port-read, single-port-write RAM with a registered read,
// so a draw reads its byte before writing it back, a scan step makes two byte reads in
// turn (a 3-bit group can straddle a byte), and a clear writes HEIGHT*(WIDTH/8+1) bytes,
// one byte per cycle (3360 at 160x160). After reset the block runs the same clearing pass
// over all bytes with busy high before it accepts its first item. busy
// drops in the cycle the result is strobed, so the next item can start there.
module subpixel_framebuffer_scanout_unit
    import sfs_pkg::*;
#(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_item i_item,
    output logic      busy,
    output logic      o_valid,
    output t_result   o_result
);

    localparam int ROW_BYTES   = WIDTH / 8 + 1;
    localparam int STORE_BYTES = HEIGHT * ROW_BYTES;
    localparam int CHUNK_COUNT = (STORE_BYTES + 2) / 3;
    localparam int GROUP_COUNT = CHUNK_COUNT * 8;
    localparam int MW          = $clog2(STORE_BYTES);
    localparam int AW          = $clog2(STORE_BYTES + 3);
    localparam int PW          = $clog2(GROUP_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_SCAN0,
        ST_SCAN1,
        ST_CLEAR
    } t_state;

    t_state         r_state, n_state;
    logic [MW-1:0]  r_addr, n_addr;
    logic [2:0]     r_bit, n_bit;
    logic           r_color, n_color;
    logic [MW-1:0]  r_clr, n_clr;
    logic           r_fill, n_fill;
    logic           r_notify, n_notify;
    logic [PW-1:0]  r_pos, n_pos;
    logic           r_v0, n_v0;
    logic           r_v1, n_v1;
    logic [2:0]     r_sh, n_sh;
    logic           r_last, n_last;
    logic [7:0]     r_b0, n_b0;
    logic           r_valid, n_valid;
    t_result        r_result, n_result;

    logic           mem_we;
    logic [MW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [MW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;

    logic           in_range;
    logic [AW-1:0]  pt_addr;
    logic [4:0]     scan_off;
    logic [AW-1:0]  scan_a0;
    logic [AW-1:0]  scan_a1;
    logic [7:0]     bit_mask;
    logic [15:0]    pair;
    logic [15:0]    pair_sh;

    sfs_store #(
        .DEPTH (STORE_BYTES),
        .AW    (MW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_range = (32'(i_item.x) < WIDTH) && (32'(i_item.y) < HEIGHT);
    assign pt_addr  = AW'(AW'(i_item.y) * AW'(ROW_BYTES)) + AW'(i_item.x[7:3]);

    // Group g of a chunk sits at bit 3*g of the 24-bit little-endian chunk.
    assign scan_off = {2'b00, r_pos[2:0]} + {1'b0, r_pos[2:0], 1'b0};
    assign scan_a0  = AW'(AW'(r_pos[PW-1:3]) << 1) + AW'(r_pos[PW-1:3]) + AW'(scan_off[4:3]);
    assign scan_a1  = scan_a0 + AW'(1);

    assign bit_mask = 8'(8'd1 << r_bit);
    assign pair     = {(r_v1 ? mem_rdata : 8'h00), r_b0};
    assign pair_sh  = pair >> r_sh;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_color   = r_color;
        n_clr     = r_clr;
        n_fill    = r_fill;
        n_notify  = r_notify;
        n_pos     = r_pos;
        n_v0      = r_v0;
        n_v1      = r_v1;
        n_sh      = r_sh;
        n_last    = r_last;
        n_b0      = r_b0;
        n_valid   = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = mem_rdata;
        mem_raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_item.kind)
                        KIND_DRAW, KIND_READ: begin
                            if (in_range) begin
                                mem_raddr = pt_addr[MW-1:0];
                                n_addr    = pt_addr[MW-1:0];
                                n_bit     = i_item.x[2:0];
                                n_color   = i_item.color;
                                n_state   = (i_item.kind == KIND_DRAW) ? ST_DRAW : ST_READ;
                            end else begin
                                n_valid  = 1'b1;
                                n_result = '0;
                            end
                        end
                        KIND_CLEAR: begin
                            n_clr    = '0;
                            n_fill   = i_item.color;
                            n_notify = 1'b1;
                            n_state  = ST_CLEAR;
                        end
                        KIND_SCAN: begin
                            n_v0      = 32'(scan_a0) < STORE_BYTES;
                            n_v1      = 32'(scan_a1) < STORE_BYTES;
                            mem_raddr = n_v0 ? scan_a0[MW-1:0] : '0;
                            n_addr    = n_v1 ? scan_a1[MW-1:0] : '0;
                            n_sh      = scan_off[2:0];
                            n_last    = 32'(r_pos) == GROUP_COUNT - 1;
                            n_pos     = n_last ? '0 : r_pos + PW'(1);
                            n_state   = ST_SCAN0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_color ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
                n_valid   = 1'b1;
                n_result  = '0;
                n_state   = ST_IDLE;
            end
            ST_READ: begin
                n_valid        = 1'b1;
                n_result       = '0;
                n_result.pixel = mem_rdata[r_bit];
                n_state        = ST_IDLE;
            end
            ST_SCAN0: begin
                n_b0      = r_v0 ? mem_rdata : 8'h00;
                mem_raddr = r_addr;
                n_state   = ST_SCAN1;
            end
            ST_SCAN1: begin
                n_valid            = 1'b1;
                n_result.pixel     = 1'b0;
                n_result.bus_word  = group_to_rgb565(pair_sh[2:0]);
                n_result.last_word = r_last;
                n_state            = ST_IDLE;
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {8{r_fill}};
                if (32'(r_clr) == STORE_BYTES - 1) begin
                    // The pass after reset has no item to answer.
                    n_valid  = r_notify;
                    n_result = '0;
                    n_state  = ST_IDLE;
                end else begin
                    n_clr = r_clr + MW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_fill   <= 1'b0;
            r_notify <= 1'b0;
            r_pos    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_fill   <= n_fill;
            r_notify <= n_notify;
            r_pos    <= n_pos;
            r_valid  <= n_valid;
        end
        r_addr   <= n_addr;
        r_bit    <= n_bit;
        r_color  <= n_color;
        r_v0     <= n_v0;
        r_v1     <= n_v1;
        r_sh     <= n_sh;
        r_last   <= n_last;
        r_b0     <= n_b0;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < GROUP_COUNT)
        else $error("scan position past the last group");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.kind == KIND_CLEAR)) |=> busy)
        else $error("clear item did not start the sweep");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != ST_SCAN0))
        else $error("result strobed in the middle of a scan step");

    a_last_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_word) |-> ($past(r_state) == ST_SCAN1))
        else $error("last word flagged outside a scan step");

    a_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (mem_we && (32'(r_clr) < STORE_BYTES)))
        else $error("clear sweep left the store");

endmodule

`default_nettype wire

/* tb/sv/tb_subpixel_framebuffer_scanout_unit.sv */
`timescale 1ns / 1ps

module tb_subpixel_framebuffer_scanout_unit;
    import sfs_pkg::*;

    localparam int WIDTH       = DEF_WIDTH;
    localparam int HEIGHT      = DEF_HEIGHT;
    localparam int ROW_BYTES   = WIDTH / 8 + 1;
    localparam int STORE_BYTES = HEIGHT * ROW_BYTES;
    localparam int CHUNK_COUNT = (STORE_BYTES + 2) / 3;
    localparam int GROUP_COUNT = CHUNK_COUNT * 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SCAN_BURST   = 30;
    localparam int CYCLE_LIMIT  = 2000000;

    // Mirror of the frame store and scan pointer, with the results still owed by the block.
    class frame_mirror;
        logic [7:0]  store [STORE_BYTES];
        int unsigned scan_pos;
        t_result     pending_results [$];
        int unsigned mismatch_count;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            scan_pos = 0;
            mismatch_count = 0;
        endfunction

        function logic [7:0] byte_at(input int unsigned idx);
            if (idx < STORE_BYTES) return store[idx];
            return 8'h00;
        endfunction

        function void note_item(input t_item it);
            t_result     r;
            logic        in_range;
            int unsigned addr;
            int unsigned pos;
            int unsigned base;
            logic [7:0]  mask;
            logic [23:0] chunk;
            logic [2:0]  grp;
            r = '0;
            in_range = (it.x < WIDTH) && (it.y < HEIGHT);
            addr = it.y * ROW_BYTES + (it.x >> 3);
            mask = 8'b1 << it.x[2:0];
            case (it.kind)
                KIND_DRAW: begin
                    if (in_range) begin
                        if (it.color) store[addr] = store[addr] | mask;
                        else store[addr] = store[addr] & ~mask;
                    end
                end
                KIND_READ: begin
                    if (in_range) r.pixel = |(store[addr] & mask);
                end
                KIND_CLEAR: begin
                    foreach (store[i]) store[i] = {8{it.color}};
                end
                KIND_SCAN: begin
                    pos = scan_pos;
                    if (pos >= GROUP_COUNT) pos = 0;
                    base = (pos >> 3) * 3;
                    chunk = {byte_at(base + 2), byte_at(base + 1), byte_at(base)};
                    grp = 3'(chunk >> (3 * (pos & 7)));
                    // Red fills the top five bits, green the middle six, blue the low five.
                    r.bus_word = {{5{grp[0]}}, {6{grp[1]}}, {5{grp[2]}}};
                    if (pos == GROUP_COUNT - 1) begin
                        r.last_word = 1'b1;
                        scan_pos = 0;
                    end else begin
                        scan_pos = pos + 1;
                    end
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding: %h", got);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.pixel !== want.pixel) begin
                $error("pixel: expected %0d, got %0d", want.pixel, got.pixel);
                mismatch_count++;
            end
            if (got.bus_word !== want.bus_word) begin
                $error("bus_word: expected %h, got %h", want.bus_word, got.bus_word);
                mismatch_count++;
            end
            if (got.last_word !== want.last_word) begin
                $error("last_word: expected %0d, got %0d", want.last_word, got.last_word);
                mismatch_count++;
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    frame_mirror mirror = new();
    bit          idle_on = 1'b1;
    logic [7:0]  last_x = 8'd0;
    logic [7:0]  last_y = 8'd0;
    int unsigned cycle_count = 0;

    subpixel_framebuffer_scanout_unit #(
        .WIDTH (WIDTH),
        .HEIGHT(HEIGHT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) mirror.check_result(o_result);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_item mk(input t_kind k, input int x, input int y, input bit c);
        t_item it;
        it.kind  = k;
        it.x     = x[7:0];
        it.y     = y[7:0];
        it.color = c;
        return it;
    endfunction

    // The item is taken at the first rising edge with start high and busy low.
    task automatic send_item(input t_item it);
        while (idle_on && $urandom_range(99) < 28) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy !== 1'b0);
        mirror.note_item(it);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (mirror.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_item random_item();
        t_item       it;
        int unsigned sel;
        int unsigned c;
        sel = $urandom_range(999);
        c   = $urandom_range(99);
        it.color = 1'($urandom_range(1));
        if (sel < 15) it.kind = KIND_CLEAR;
        else if (sel < 360) it.kind = KIND_DRAW;
        else if (sel < 660) it.kind = KIND_READ;
        else it.kind = KIND_SCAN;
        if (it.kind == KIND_READ && c < 40) begin
            it.x = last_x;
            it.y = last_y;
        end else if (c < 45) begin
            it.x = 8'($urandom_range(255));
            it.y = 8'($urandom_range(255));
        end else if (c < 75) begin
            // Rows near the top are where the scan pointer spends most of the run.
            it.x = 8'($urandom_range(WIDTH - 1));
            it.y = 8'($urandom_range(7));
        end else if (c < 85) begin
            it.x = 8'($urandom_range(WIDTH - 1));
            it.y = 8'($urandom_range(HEIGHT - 1, HEIGHT - 10));
        end else begin
            it.x = 8'($urandom_range(WIDTH - 1));
            it.y = 8'($urandom_range(HEIGHT - 1));
        end
        if (it.kind == KIND_DRAW) begin
            last_x = it.x;
            last_y = it.y;
        end
        return it;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(mk(KIND_READ, 0, 0, 1'b0));
        send_item(mk(KIND_DRAW, 0, 0, 1'b1));
        send_item(mk(KIND_READ, 0, 0, 1'b0));
        send_item(mk(KIND_DRAW, 1, 0, 1'b1));
        send_item(mk(KIND_DRAW, 2, 0, 1'b1));
        // Bits 6 to 8 form a group that straddles the first two bytes.
        send_item(mk(KIND_DRAW, 8, 0, 1'b1));
        send_item(mk(KIND_DRAW, 159, 159, 1'b1));
        send_item(mk(KIND_READ, 159, 159, 1'b0));
        send_item(mk(KIND_DRAW, 255, 255, 1'b1));
        send_item(mk(KIND_READ, 255, 255, 1'b1));
        send_item(mk(KIND_DRAW, 160, 5, 1'b1));
        send_item(mk(KIND_READ, 160, 5, 1'b0));
        send_item(mk(KIND_DRAW, 3, 160, 1'b1));
        send_item(mk(KIND_READ, 3, 160, 1'b0));
        repeat (4) send_item(mk(KIND_SCAN, 0, 0, 1'b0));
        send_item(mk(KIND_CLEAR, 0, 0, 1'b1));
        send_item(mk(KIND_READ, 200, 7, 1'b0));
        send_item(mk(KIND_READ, 10, 10, 1'b0));
        send_item(mk(KIND_SCAN, 255, 255, 1'b1));
        send_item(mk(KIND_DRAW, 10, 10, 1'b0));
        send_item(mk(KIND_READ, 10, 10, 1'b0));
        send_item(mk(KIND_CLEAR, 0, 0, 1'b0));
        send_item(mk(KIND_SCAN, 0, 0, 1'b0));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = !(i >= 700 && i < 1000);
            if (i == 1200) drain_results();
            send_item(random_item());
        end
        idle_on = 1'b1;

        // A closing run of scan steps whose unused fields carry noise.
        for (int n = 0; n < SCAN_BURST; n++) begin
            send_item(mk(KIND_SCAN, int'($urandom_range(255)), int'($urandom_range(255)),
                         1'($urandom_range(1))));
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (mirror.mismatch_count == 0 && mirror.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sfs_pkg.sv
rtl/sfs_store.sv
rtl/subpixel_framebuffer_scanout_unit.sv
tb/sv/tb_subpixel_framebuffer_scanout_unit.sv
